>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/qpc_pkg.sv
// Shared widths, register indexes and controller interface types.
package qpc_pkg;

   localparam int RPM_BITS      = 26;
   localparam int NUM_BITS      = 24;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_MAGNET_COUNT     = 3'd0,
      REG_INVERT_DIRECTION = 3'd1,
      REG_TICK_RATE_HZ     = 3'd2,
      REG_MIN_PERIOD_TICKS = 3'd3,
      REG_MAX_IDLE_TICKS   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic mult;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic ref_ok;
      logic div_done;
   } ctrl_status_type;

endpackage

>>> rtl/qpc_req_if.sv
// Input channel carrying one sampling tick with two sensor pin levels.
interface qpc_req_if;
   logic valid;
   logic ready;
   logic pin_a;
   logic pin_b;

   modport source (output valid, output pin_a, output pin_b, input ready);
   modport sink (input valid, input pin_a, input pin_b, output ready);
endinterface

>>> rtl/qpc_rsp_if.sv
// Result channel carrying the cadence value and the reference edge flag.
interface qpc_rsp_if import qpc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [RPM_BITS-1:0] rpm_x16;
   logic                       reference_edge;

   modport source (output valid, output rpm_x16, output reference_edge, input ready);
   modport sink (input valid, input rpm_x16, input reference_edge, output ready);
endinterface

>>> rtl/qpc_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module qpc_divider import qpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numerator,
   input  logic [NUM_BITS-1:0] divisor,
   input  logic                divisor_big,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(NUM_BITS);
   localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(NUM_BITS - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [NUM_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [NUM_BITS-1:0] div_ff, div_in;
   logic [NUM_BITS:0]   trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      trial    = {rem_ff, quo_ff[NUM_BITS-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         // A divisor wider than the numerator always gives a zero quotient, so its
         // low bits are replaced by a nonzero value that no trial can reach.
         quo_in   = divisor_big ? '0 : numerator;
         div_in   = divisor_big ? '1 : divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = NUM_BITS'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[NUM_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/qpc_datapath.sv
// Datapath: registers, phase decoding, period product, divider, cadence update and output register.
module qpc_datapath import qpc_pkg::*; #(
   parameter int TICK_COUNTER_BITS   = 32,
   parameter int DIRECTION_THRESHOLD = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]   csr_prdata,
   input  logic                       pin_a,
   input  logic                       pin_b,
   input  ctrl_cmd_type               cmd,
   output ctrl_status_type            status,
   output logic signed [RPM_BITS-1:0] rsp_rpm_x16,
   output logic                       rsp_reference_edge
);

   localparam int PW = TICK_COUNTER_BITS + 8;
   localparam logic [TICK_COUNTER_BITS-1:0] TICK_MAX = '1;
   localparam logic [7:0] THRESH = 8'(DIRECTION_THRESHOLD);
   localparam logic [1:0] REF_PHASE = 2'd3;
   localparam logic signed [RPM_BITS:0] RPM_LIMIT = 27'sd19200000;
   localparam logic signed [2:0] STEP_TABLE [16] = '{
      3'sd0, -3'sd1, 3'sd1, 3'sd2, 3'sd1, 3'sd0, 3'sd2, -3'sd1,
      -3'sd1, 3'sd2, 3'sd0, 3'sd1, 3'sd2, 3'sd1, -3'sd1, 3'sd0
   };

   logic [7:0]  magnet_ff, magnet_in;
   logic        invert_ff, invert_in;
   logic [13:0] rate_ff, rate_in;
   logic [19:0] min_ff, min_in;
   logic [19:0] max_idle_ff, max_idle_in;

   logic [1:0]                    prev_phase_ff, prev_phase_in;
   logic [7:0]                    fsc_ff, fsc_in;
   logic [TICK_COUNTER_BITS-1:0]  tsr_ff, tsr_in;
   logic [31:0]                   idle_ff, idle_in;
   logic signed [RPM_BITS-1:0]    cadence_ff, cadence_in;

   logic [1:0]                    phase_ff, phase_in;
   logic signed [2:0]             step_ff, step_in;
   logic                          ref_ff, ref_in;
   logic [TICK_COUNTER_BITS-1:0]  snap_ff, snap_in;
   logic [PW-1:0]                 period_ff, period_in;
   logic signed [RPM_BITS-1:0]    rpm_ff, rpm_in;
   logic                          edge_ff, edge_in;

   logic                          csr_write;
   logic signed [2:0]             step_raw;
   logic [7:0]                    fsc_upd;
   logic [TICK_COUNTER_BITS-1:0]  tsr_inc;
   logic [31:0]                   idle_inc;
   logic                          period_ok;
   logic [NUM_BITS-1:0]           numerator;
   logic                          div_done;
   logic [NUM_BITS-1:0]           quotient;
   logic signed [RPM_BITS:0]      q_ext;
   logic signed [RPM_BITS:0]      prod;
   logic signed [RPM_BITS:0]      clamped;

   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      magnet_in   = magnet_ff;
      invert_in   = invert_ff;
      rate_in     = rate_ff;
      min_in      = min_ff;
      max_idle_in = max_idle_ff;
      if (csr_write) begin
         case (reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]))
            REG_MAGNET_COUNT:     magnet_in   = csr_pwdata[7:0];
            REG_INVERT_DIRECTION: invert_in   = csr_pwdata[0];
            REG_TICK_RATE_HZ:     rate_in     = csr_pwdata[13:0];
            REG_MIN_PERIOD_TICKS: min_in      = csr_pwdata[19:0];
            REG_MAX_IDLE_TICKS:   max_idle_in = csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]))
         REG_MAGNET_COUNT:     csr_prdata = CSR_DATA_BITS'(magnet_ff);
         REG_INVERT_DIRECTION: csr_prdata = CSR_DATA_BITS'(invert_ff);
         REG_TICK_RATE_HZ:     csr_prdata = CSR_DATA_BITS'(rate_ff);
         REG_MIN_PERIOD_TICKS: csr_prdata = CSR_DATA_BITS'(min_ff);
         REG_MAX_IDLE_TICKS:   csr_prdata = CSR_DATA_BITS'(max_idle_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign step_raw  = STEP_TABLE[{prev_phase_ff, phase_ff}];
   assign tsr_inc   = (tsr_ff == TICK_MAX) ? tsr_ff : tsr_ff + 1'b1;
   assign idle_inc  = (idle_ff == 32'hFFFF_FFFF) ? idle_ff : idle_ff + 1'b1;
   assign period_ok = (period_ff != '0) && (period_ff >= PW'(min_ff));
   assign numerator = NUM_BITS'(rate_ff) * NUM_BITS'(960);
   assign q_ext     = $signed({3'b000, quotient});

   always_comb begin
      step_in = invert_ff ? -step_raw : step_raw;
      fsc_upd = fsc_ff;
      if (step_in == 3'sd1) begin
         if (fsc_ff != 8'hFF) begin
            fsc_upd = fsc_ff + 1'b1;
         end
      end else if (step_in == -3'sd1) begin
         fsc_upd = '0;
      end
   end

   always_comb begin
      case (step_ff)
         3'b001:  prod = q_ext;
         3'b111:  prod = -q_ext;
         3'b010:  prod = q_ext <<< 1;
         3'b110:  prod = -(q_ext <<< 1);
         default: prod = '0;
      endcase
      if (prod > RPM_LIMIT) begin
         clamped = RPM_LIMIT;
      end else if (prod < -RPM_LIMIT) begin
         clamped = -RPM_LIMIT;
      end else begin
         clamped = prod;
      end
   end

   always_comb begin
      prev_phase_in = prev_phase_ff;
      fsc_in        = fsc_ff;
      tsr_in        = tsr_ff;
      idle_in       = idle_ff;
      cadence_in    = cadence_ff;
      phase_in      = phase_ff;
      ref_in        = ref_ff;
      snap_in       = snap_ff;
      period_in     = period_ff;
      rpm_in        = rpm_ff;
      edge_in       = edge_ff;
      if (cmd.load) begin
         phase_in = {pin_b, pin_a};
      end
      if (cmd.eval) begin
         prev_phase_in = phase_ff;
         fsc_in        = fsc_upd;
         ref_in        = (phase_ff == REF_PHASE) && (fsc_upd >= THRESH);
         snap_in       = tsr_inc;
         tsr_in        = ref_in ? '0 : tsr_inc;
      end
      if (cmd.mult) begin
         period_in = PW'(snap_ff) * PW'(magnet_ff);
      end
      if (cmd.commit) begin
         edge_in = 1'b0;
         if (ref_ff) begin
            if (period_ok) begin
               cadence_in = $signed(clamped[RPM_BITS-1:0]);
               idle_in    = '0;
               fsc_in     = '0;
               edge_in    = 1'b1;
            end
         end else begin
            idle_in = idle_inc;
            if (idle_inc > {12'd0, max_idle_ff}) begin
               cadence_in = '0;
            end
         end
         rpm_in = cadence_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magnet_ff     <= 8'd24;
         invert_ff     <= 1'b0;
         rate_ff       <= 14'd100;
         min_ff        <= 20'd16;
         max_idle_ff   <= 20'd30;
         prev_phase_ff <= '0;
         fsc_ff        <= '0;
         tsr_ff        <= '0;
         idle_ff       <= '0;
         cadence_ff    <= '0;
      end else begin
         magnet_ff     <= magnet_in;
         invert_ff     <= invert_in;
         rate_ff       <= rate_in;
         min_ff        <= min_in;
         max_idle_ff   <= max_idle_in;
         prev_phase_ff <= prev_phase_in;
         fsc_ff        <= fsc_in;
         tsr_ff        <= tsr_in;
         idle_ff       <= idle_in;
         cadence_ff    <= cadence_in;
      end
      phase_ff  <= phase_in;
      ref_ff    <= ref_in;
      snap_ff   <= snap_in;
      period_ff <= period_in;
      rpm_ff    <= rpm_in;
      edge_ff   <= edge_in;
      if (cmd.eval) begin
         step_ff <= step_in;
      end
   end

   qpc_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .numerator   (numerator),
      .divisor     (period_ff[NUM_BITS-1:0]),
      .divisor_big ((period_ff >> NUM_BITS) != '0),
      .done        (div_done),
      .quotient    (quotient)
   );

   assign status.ref_ok   = ref_ff && period_ok;
   assign status.div_done = div_done;

   assign rsp_rpm_x16        = rpm_ff;
   assign rsp_reference_edge = edge_ff;

endmodule

>>> rtl/qpc_ctrl.sv
// Controller state machine that sequences one tick through the datapath.
module qpc_ctrl import qpc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MULT,
      ST_DECIDE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.ref_ok) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/quadrature_pedal_cadence_top.sv
// Top level of the quadrature pedal cadence block.
// Each transaction on req_chan is one sampling tick and yields exactly one
// transaction on rsp_chan. A plain tick steps through the eval, multiply, decide
// and finish states before its result is registered for output; a tick that
// completes a valid reference edge also waits in the divide state on the 24-step
// one-bit-per-cycle divider that forms 960*tick_rate_hz/period. A result that
// still waits in the output register stalls the commit of the next tick. One
// tick is in work at a time; the next is accepted while a finished result still
// waits in the output register. Configuration registers sit at byte addresses 4*i.
`include "assert_macros.svh"

module quadrature_pedal_cadence_top import qpc_pkg::*; #(
   parameter int TICK_COUNTER_BITS   = 32,
   parameter int DIRECTION_THRESHOLD = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   qpc_req_if.sink                  req_chan,
   qpc_rsp_if.source                rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;
   logic            rsp_valid;

   assign csr_pready     = 1'b1;
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   qpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   qpc_datapath #(
      .TICK_COUNTER_BITS   (TICK_COUNTER_BITS),
      .DIRECTION_THRESHOLD (DIRECTION_THRESHOLD)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .pin_a              (req_chan.pin_a),
      .pin_b              (req_chan.pin_b),
      .cmd                (cmd),
      .status             (status),
      .rsp_rpm_x16        (rsp_chan.rpm_x16),
      .rsp_reference_edge (rsp_chan.reference_edge)
   );

   // An accepted tick blocks further input until its result is committed.
   `ASSERT_NEXT(a_one_tick_in_work, clock, reset, req_chan.valid && req_ready, !req_ready)
   // A result is only committed when the output register can take it.
   `ASSERT_IMPLIES(a_commit_free, clock, reset, cmd.commit, !rsp_valid || rsp_chan.ready)
   // A committed result is offered in the following cycle.
   `ASSERT_NEXT(a_commit_shown, clock, reset, cmd.commit, rsp_valid)

endmodule
